// ===== sv/lbm_pkg.sv =====
// Package: shared types, constants and fixed-point helpers for the D2Q9 collision block.
`default_nettype none
package lbm_pkg;

  localparam int NDIR = 9;

  typedef logic signed [31:0] word_t;

  // Configuration register indexes.
  localparam logic REG_RATE = 1'b0;
  localparam logic REG_GAIN = 1'b1;

  // Lattice direction components, order: rest, +x, +y, -x, -y, +x+y, -x+y, -x-y, +x-y.
  localparam logic signed [1:0] DIR_X [NDIR] = '{2'sd0, 2'sd1, 2'sd0, -2'sd1, 2'sd0,
                                                 2'sd1, -2'sd1, -2'sd1, 2'sd1};
  localparam logic signed [1:0] DIR_Y [NDIR] = '{2'sd0, 2'sd0, 2'sd1, 2'sd0, -2'sd1,
                                                 2'sd1, 2'sd1, -2'sd1, -2'sd1};

  // Weight classes.
  typedef enum logic [1:0] {
    WT_REST = 2'd0,
    WT_AXIS = 2'd1,
    WT_DIAG = 2'd2
  } wt_class_t;

  localparam wt_class_t WT_OF [NDIR] = '{WT_REST, WT_AXIS, WT_AXIS, WT_AXIS, WT_AXIS,
                                         WT_DIAG, WT_DIAG, WT_DIAG, WT_DIAG};

  localparam logic signed [31:0] INT32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] INT32_MIN = 32'sh80000000;

  // ceil(2^35 / 9): floor(n * RECIP9 / 2^35) equals floor(n / 9) for any 32-bit n.
  localparam logic [31:0] RECIP9 = 32'd3817748708;

  // Saturate a 72-bit signed value to 32 bits.
  function automatic word_t sat32(input logic signed [71:0] v);
    word_t r;
    if (v > 72'sd2147483647) begin
      r = INT32_MAX;
    end else if (v < -72'sd2147483648) begin
      r = INT32_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Round-half-up arithmetic shift right by s (s >= 1), 72-bit.
  function automatic logic signed [71:0] shr_rnd(input logic signed [71:0] v,
                                                  input int unsigned s);
    logic signed [71:0] t;
    t = v + (72'sd1 <<< s) / 2;
    return t >>> s;
  endfunction

  // Apply weight 4/9, 1/9 or 1/36, rounded to nearest, ties away from zero.
  // Rest: with |x| = 9q + r, (4|x| + 4) / 9 rounds down to 4q + r/2.
  // Diagonal: (|x| + 18) / 36 is ((|x| + 18) / 4) / 9, both rounded down.
  function automatic word_t weigh(input wt_class_t c, input word_t x);
    logic [31:0] mag;
    logic [31:0] n;
    logic [63:0] prod;
    logic [31:0] q;
    logic [31:0] r;
    logic [31:0] res;
    mag = x[31] ? -x : x;
    unique case (c)
      WT_DIAG: n = 32'((33'(mag) + 33'd18) >> 2);
      WT_AXIS: n = mag + 32'd4;
      default: n = mag;
    endcase
    prod = 64'(n) * 64'(RECIP9);
    q    = 32'(prod[63:35]);
    r    = n - ((q << 3) + q);
    res  = (c == WT_REST) ? ((q << 2) + (r >> 1)) : q;
    return x[31] ? word_t'(-$signed(res)) : word_t'(res);
  endfunction

endpackage
`default_nettype wire

// ===== sv/lbm_div.sv =====
// Pipelined restoring divider: fixed-point quotient, truncated toward zero, saturated.
`default_nettype none
module lbm_div #(
  parameter int FRAC_BITS = 28
) (
  input  wire                  clk,
  input  wire [2:0]            num_hi,
  input  wire lbm_pkg::word_t  num,
  input  wire lbm_pkg::word_t  den,
  output lbm_pkg::word_t       quo
);
  import lbm_pkg::*;

  localparam int STEPS = 36 + FRAC_BITS;
  localparam int NW    = 36 + FRAC_BITS;

  logic [NW-1:0] un_r  [STEPS+1];
  logic [32:0]   ud_r  [STEPS+1];
  logic [34:0]   rem_r [STEPS+1];
  logic [33:0]   q_r   [STEPS+1];
  logic          neg_r [STEPS+1];
  logic          dz_r  [STEPS+1];

  // The numerator is 35-bit signed: num_hi carries its top bits.
  logic signed [34:0] wnum;
  logic        [35:0] nmag;
  assign wnum = {num_hi, num};
  assign nmag = wnum[34] ? 36'(-36'(wnum)) : 36'(wnum);

  // Stage zero: magnitudes.
  always_ff @(posedge clk) begin
    un_r[0]  <= NW'(nmag) << FRAC_BITS;
    ud_r[0]  <= den[31] ? 33'(-$signed({den[31], den})) : 33'({1'b0, den});
    rem_r[0] <= '0;
    q_r[0]   <= '0;
    neg_r[0] <= wnum[34] ^ den[31];
    dz_r[0]  <= (den == '0);
  end

  // One quotient bit per stage; quotient pins at 2^32 once it passes it.
  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic [35:0] rs;
    logic [34:0] rn;
    logic [33:0] qn;
    always_comb begin
      rs = {rem_r[s], un_r[s][NW-1-s]};
      qn = {q_r[s][32:0], 1'b0};
      if (q_r[s] >= 34'h100000000) begin
        rn = rem_r[s];
        qn = 34'h100000000;
      end else if (rs >= 36'(ud_r[s])) begin
        rn = 35'(rs - 36'(ud_r[s]));
        qn = qn | 34'd1;
      end else begin
        rn = rs[34:0];
      end
      if (qn > 34'h100000000) qn = 34'h100000000;
    end
    always_ff @(posedge clk) begin
      un_r[s+1]  <= un_r[s];
      ud_r[s+1]  <= ud_r[s];
      rem_r[s+1] <= rn;
      q_r[s+1]   <= qn;
      neg_r[s+1] <= neg_r[s];
      dz_r[s+1]  <= dz_r[s];
    end
  end

  always_comb begin
    if (dz_r[STEPS]) begin
      quo = '0;
    end else if (neg_r[STEPS]) begin
      quo = sat32(-72'($signed({1'b0, q_r[STEPS]})));
    end else begin
      quo = sat32(72'($signed({1'b0, q_r[STEPS]})));
    end
  end
endmodule
`default_nettype wire

// ===== sv/lbm_lane.sv =====
// Collision lane: equilibrium, relaxation and forcing for one direction, pipelined.
`default_nettype none
module lbm_lane #(
  parameter int FRAC_BITS = 28,
  parameter int DIR       = 0
) (
  input  wire                  clk,
  input  wire lbm_pkg::word_t  f_in,
  input  wire lbm_pkg::word_t  rho,
  input  wire lbm_pkg::word_t  vx,
  input  wire lbm_pkg::word_t  uy,
  input  wire lbm_pkg::word_t  third,
  input  wire lbm_pkg::word_t  coef,
  input  wire lbm_pkg::word_t  body_frc,
  input  wire lbm_pkg::word_t  rate,
  input  wire lbm_pkg::word_t  one,
  output lbm_pkg::word_t       post
);
  import lbm_pkg::*;

  localparam logic signed [1:0] CX = DIR_X[DIR];
  localparam logic signed [1:0] CY = DIR_Y[DIR];
  localparam wt_class_t         WC = WT_OF[DIR];

  // Stage 1: first-order term, forcing inner term.
  word_t first_r, inner_r, d1_r, rho1_r, th1_r, co1_r, f1_r, rt1_r;
  always_ff @(posedge clk) begin
    first_r <= sat32(72'sd3 * (72'(CX) * 72'(vx) + 72'(CY) * 72'(uy)));
    d1_r    <= f_in; rho1_r <= rho; th1_r <= third;
    co1_r   <= coef; f1_r <= body_frc; rt1_r <= rate;
  end
  always_ff @(posedge clk) begin
    inner_r <= sat32(72'(CY) * 72'(one) - 72'(uy) +
                     72'(sat32(72'sd3 * (72'(CX) * 72'(vx) + 72'(CY) * 72'(uy)))) * 72'(CY));
  end

  // Stage 2: second-order term; coef * inner.
  word_t second_r, ci_r, first2_r, d2_r, rho2_r, th2_r, f2_r, rt2_r;
  always_ff @(posedge clk) begin
    second_r <= sat32(shr_rnd(72'(first_r) * 72'(first_r), FRAC_BITS + 1));
    ci_r     <= sat32(shr_rnd(72'(co1_r) * 72'(inner_r), FRAC_BITS));
    first2_r <= first_r; d2_r <= d1_r; rho2_r <= rho1_r; th2_r <= th1_r;
    f2_r <= f1_r; rt2_r <= rt1_r;
  end

  // Stage 3: series; forcing product.
  word_t series_r, cf_r, d3_r, rho3_r, rt3_r;
  always_ff @(posedge clk) begin
    series_r <= sat32(72'(one) + 72'(first2_r) + 72'(second_r) + 72'(th2_r));
    cf_r     <= sat32(shr_rnd(72'(ci_r) * 72'(f2_r), FRAC_BITS));
    d3_r <= d2_r; rho3_r <= rho2_r; rt3_r <= rt2_r;
  end

  // Stage 4: rho * series; forcing weight.
  word_t rs_r, term_r, d4_r, rt4_r;
  always_ff @(posedge clk) begin
    rs_r   <= sat32(shr_rnd(72'(rho3_r) * 72'(series_r), FRAC_BITS));
    term_r <= weigh(WC, cf_r);
    d4_r <= d3_r; rt4_r <= rt3_r;
  end

  // Stage 5: equilibrium and difference.
  word_t diff_r, term5_r, d5_r, rt5_r;
  always_ff @(posedge clk) begin
    diff_r  <= sat32(72'(d4_r) - 72'(weigh(WC, rs_r)));
    term5_r <= term_r; d5_r <= d4_r; rt5_r <= rt4_r;
  end

  // Stage 6: relax.
  word_t rel_r, term6_r, d6_r;
  always_ff @(posedge clk) begin
    rel_r   <= sat32(shr_rnd(72'(rt5_r) * 72'(diff_r), FRAC_BITS));
    term6_r <= term5_r; d6_r <= d5_r;
  end

  // Stage 7: add forcing.
  always_ff @(posedge clk) begin
    post <= sat32(72'(sat32(72'(d6_r) - 72'(rel_r))) + 72'(term6_r));
  end
endmodule
`default_nettype wire

// ===== sv/lbm_d2q9_cell_collision.sv =====
// Top level: D2Q9 BGK collision of one lattice cell with vertical body force.
// One cell word is taken per clock whenever busy is low; busy is tied low, so the block
// accepts a new cell in every cycle. Each result appears on the out_ ports for one cycle
// with out_valid high, and the word is taken at the edge that follows. Most of the pipeline
// is the pipelined velocity divider, one quotient bit per stage; two moment stages, two
// velocity stages and seven lane stages make up the rest. The receiver cannot stall the
// output.
// Configuration writes are taken at once (cfg_ready high) and must only be made while
// no cell is in flight.
`default_nettype none
module lbm_d2q9_cell_collision #(
  parameter int FRAC_BITS = 28
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  wire lbm_pkg::word_t  in_dist_0, in_dist_1, in_dist_2, in_dist_3, in_dist_4,
  input  wire lbm_pkg::word_t  in_dist_5, in_dist_6, in_dist_7, in_dist_8,
  input  wire lbm_pkg::word_t  in_cell_temperature,
  output logic                 out_valid,
  output lbm_pkg::word_t       out_post_0, out_post_1, out_post_2, out_post_3, out_post_4,
  output lbm_pkg::word_t       out_post_5, out_post_6, out_post_7, out_post_8,
  output lbm_pkg::word_t       out_cell_density,
  output lbm_pkg::word_t       out_velocity_x,
  output lbm_pkg::word_t       out_velocity_y,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire                  cfg_index,
  input  wire lbm_pkg::word_t  cfg_data
);
  import lbm_pkg::*;

  localparam int    DIV_LAT  = 37 + FRAC_BITS;
  localparam int    LANE_LAT = 7;
  localparam int    LAT      = 2 + DIV_LAT + 2 + LANE_LAT;
  localparam logic signed [71:0] ONE_W = (FRAC_BITS >= 31) ? 72'sd2147483647
                                                           : (72'sd1 <<< FRAC_BITS);
  localparam word_t ONE = ONE_W[31:0];

  logic [28:0] rate_r;
  word_t       gain_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Hold configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= 29'd268435456;
      gain_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RATE: rate_r <= cfg_data[28:0];
        REG_GAIN: gain_r <= cfg_data;
        default:  ;
      endcase
    end
  end

  word_t din [NDIR];
  assign din = '{in_dist_0, in_dist_1, in_dist_2, in_dist_3, in_dist_4,
                 in_dist_5, in_dist_6, in_dist_7, in_dist_8};

  // Stage A: moments and acceleration.
  word_t rho_a_r, mx_a_r, my_a_r, acc_a_r;
  logic signed [71:0] s_sum, s_mx, s_my;
  always_comb begin
    s_sum = '0; s_mx = '0; s_my = '0;
    for (int k = 0; k < NDIR; k++) begin
      s_sum = s_sum + 72'(din[k]);
      s_mx  = s_mx + 72'(DIR_X[k]) * 72'(din[k]);
      s_my  = s_my + 72'(DIR_Y[k]) * 72'(din[k]);
    end
  end
  word_t dist_a_r [NDIR];
  always_ff @(posedge clk) begin
    rho_a_r  <= sat32(s_sum);
    mx_a_r   <= s_mx[31:0];
    my_a_r   <= s_my[31:0];
    acc_a_r  <= sat32(shr_rnd(72'(gain_r) * 72'(in_cell_temperature), FRAC_BITS));
    dist_a_r <= din;
  end
  // mx, my fit in 35 signed bits; carry their top bits alongside.
  logic [2:0] mxh_a_r, myh_a_r;
  always_ff @(posedge clk) begin
    mxh_a_r <= s_mx[34:32];
    myh_a_r <= s_my[34:32];
  end

  // Stage B: force product; momenta enter the dividers as 35 bits, top bits carried beside.
  word_t rho_b_r, acc_b_r, force_b_r, mx_b_r, my_b_r;
  always_ff @(posedge clk) begin
    rho_b_r   <= rho_a_r;
    acc_b_r   <= acc_a_r;
    force_b_r <= sat32(shr_rnd(72'(rho_a_r) * 72'(acc_a_r), FRAC_BITS));
    mx_b_r    <= mx_a_r;
    my_b_r    <= my_a_r;
  end
  logic [2:0] mxh_b_r, myh_b_r;
  always_ff @(posedge clk) begin
    mxh_b_r <= mxh_a_r;
    myh_b_r <= myh_a_r;
  end

  // Divide the 35-bit momentum, top bits carried beside the low word, by rho.
  word_t vx_q, vy_q;
  lbm_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk(clk), .num_hi(mxh_b_r), .num(mx_b_r), .den(rho_b_r), .quo(vx_q));
  lbm_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk(clk), .num_hi(myh_b_r), .num(my_b_r), .den(rho_b_r), .quo(vy_q));

  // Delay line for side data across the divider.
  word_t dl_rho [DIV_LAT+1];
  word_t dl_acc [DIV_LAT+1];
  word_t dl_frc [DIV_LAT+1];
  word_t dl_dst [DIV_LAT+1][NDIR];
  always_ff @(posedge clk) begin
    dl_rho[0] <= rho_b_r; dl_acc[0] <= acc_b_r; dl_frc[0] <= force_b_r;
    dl_dst[0] <= dist_a_r;
    for (int i = 0; i < DIV_LAT; i++) begin
      dl_rho[i+1] <= dl_rho[i]; dl_acc[i+1] <= dl_acc[i];
      dl_frc[i+1] <= dl_frc[i]; dl_dst[i+1] <= dl_dst[i];
    end
  end
  // dist_a_r skips Stage B; realign by taking it one stage later in the delay line.
  word_t rho_c, acc_c, frc_c;
  word_t dst_c [NDIR];
  assign rho_c = dl_rho[DIV_LAT-1];
  assign acc_c = dl_acc[DIV_LAT-1];
  assign frc_c = dl_frc[DIV_LAT-1];
  assign dst_c = dl_dst[DIV_LAT];

  // Stage C: shifted vertical velocity and velocity squares.
  word_t uy_c_r, vx_c_r, vy_c_r, rho_c_r, frc_c_r, vxx_c_r, uyy_c_r;
  word_t dst_c_r [NDIR];
  word_t uy_n;
  assign uy_n = sat32(72'(vy_q) + shr_rnd(72'(acc_c), 1));
  always_ff @(posedge clk) begin
    uy_c_r  <= uy_n;
    vx_c_r  <= vx_q;
    vy_c_r  <= vy_q;
    rho_c_r <= rho_c;
    frc_c_r <= frc_c;
    vxx_c_r <= sat32(shr_rnd(72'(vx_q) * 72'(vx_q), FRAC_BITS));
    uyy_c_r <= sat32(shr_rnd(72'(uy_n) * 72'(uy_n), FRAC_BITS));
    dst_c_r <= dst_c;
  end

  // Stage D: third term and force coefficient.
  word_t uy_d_r, vx_d_r, vy_d_r, rho_d_r, frc_d_r, third_d_r, coef_d_r;
  word_t dst_d_r [NDIR];
  word_t usq;
  assign usq = sat32(72'(vxx_c_r) + 72'(uyy_c_r));
  always_ff @(posedge clk) begin
    uy_d_r <= uy_c_r; vx_d_r <= vx_c_r; vy_d_r <= vy_c_r;
    rho_d_r <= rho_c_r; frc_d_r <= frc_c_r; dst_d_r <= dst_c_r;
    third_d_r <= sat32(-shr_rnd(72'sd3 * 72'(usq), 1));
    coef_d_r  <= sat32(72'sd3 * 72'(sat32(ONE_W - shr_rnd(72'($signed({1'b0, rate_r})), 1))));
  end

  // Lanes.
  word_t post [NDIR];
  for (genvar k = 0; k < NDIR; k++) begin : g_lane
    lbm_lane #(.FRAC_BITS(FRAC_BITS), .DIR(k)) u_lane (
      .clk(clk), .f_in(dst_d_r[k]), .rho(rho_d_r), .vx(vx_d_r), .uy(uy_d_r),
      .third(third_d_r), .coef(coef_d_r), .body_frc(frc_d_r),
      .rate(32'($signed({1'b0, rate_r}))), .one(ONE), .post(post[k]));
  end

  // Merge: align moments with lane outputs.
  word_t mg_rho [LANE_LAT], mg_vx [LANE_LAT], mg_vy [LANE_LAT];
  always_ff @(posedge clk) begin
    mg_rho[0] <= rho_d_r; mg_vx[0] <= vx_d_r; mg_vy[0] <= vy_d_r;
    for (int i = 1; i < LANE_LAT; i++) begin
      mg_rho[i] <= mg_rho[i-1]; mg_vx[i] <= mg_vx[i-1]; mg_vy[i] <= mg_vy[i-1];
    end
  end

  // Valid pipeline.
  logic [LAT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[LAT-2:0], start && !busy};
  end

  assign out_valid  = vld_r[LAT-1];
  assign out_post_0 = post[0]; assign out_post_1 = post[1]; assign out_post_2 = post[2];
  assign out_post_3 = post[3]; assign out_post_4 = post[4]; assign out_post_5 = post[5];
  assign out_post_6 = post[6]; assign out_post_7 = post[7]; assign out_post_8 = post[8];
  assign out_cell_density = mg_rho[LANE_LAT-1];
  assign out_velocity_x   = mg_vx[LANE_LAT-1];
  assign out_velocity_y   = mg_vy[LANE_LAT-1];

  // Drop-in checks.
  a_busy_low: assert property (@(posedge clk) busy == 1'b0)
    else $error("busy raised");
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    $past(vld_r[LAT-2]) |-> out_valid)
    else $error("result lost in pipeline");
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_index == REG_GAIN) |=> gain_r == $past(cfg_data))
    else $error("gain write lost");
endmodule
`default_nettype wire
